### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TTFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ttfs_pkg.sv
// ----------------------------------------------------------------------------
// ttfs_pkg
// types and constants shared by the tempo tick frame scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttfs_pkg;

    localparam int TICK_COUNT_BITS = 15;
    localparam int PROD_W          = 32 + TICK_COUNT_BITS;

    localparam int SR_W    = 18;
    localparam int BPM_W   = 17;
    localparam int PPQ_W   = 9;
    localparam int CFG_W   = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_BPM_Q8   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BEAT = 2'd2;

    localparam int RESET_SAMPLE_RATE = 44100;
    localparam int RESET_BPM_Q8      = 32000;
    localparam int RESET_PPQ         = 24;

    // divider: (rate*60) << 24 over ppq*bpm_q8
    localparam int NUM_W      = 48;
    localparam int DEN_W      = PPQ_W + BPM_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    localparam longint RESET_HALF_RAW =
        (longint'(RESET_SAMPLE_RATE) * 30 * 256) / (longint'(RESET_PPQ) * RESET_BPM_Q8);
    localparam logic [15:0] RESET_HALF_LEN =
        (RESET_HALF_RAW > 65535) ? 16'hFFFF : 16'(RESET_HALF_RAW);
    localparam longint RESET_REAL_RAW =
        ((longint'(RESET_SAMPLE_RATE) * 60) << 24) / (longint'(RESET_PPQ) * RESET_BPM_Q8);
    localparam logic [31:0] RESET_REAL = 32'(RESET_REAL_RAW);

    typedef struct packed {
        logic start;
        logic step;
        logic mul;
        logic finish;
        logic plain;
    } ttfs_cmd_t;

    typedef struct packed {
        logic tick_due;
    } ttfs_status_t;

endpackage

`default_nettype wire

### src/tempo_tick_frame_scheduler_top.sv
// ----------------------------------------------------------------------------
// tempo_tick_frame_scheduler_top
// splits a stream of audio frames into tempo ticks, one result per frame
// ----------------------------------------------------------------------------
// A frame that does not begin a tick has its result registered in the cycle
// after it is accepted. For a frame that begins a tick, the new Q16.16 tick
// length comes from a restoring divider that produces one of 48 quotient bits
// per cycle, followed by a multiply step for the tick offset and a finish step
// that settles the tick length once the output is free. Register writes take
// effect at the next tick start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tempo_tick_frame_scheduler_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ttfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ttfs_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            block_last,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 tick_start,
    output logic [14:0]                          tick_index,
    output logic [15:0]                          frame_in_tick,
    output logic [15:0]                          tick_frames,
    output logic                                 chunk_start
);

    ttfs_pkg::ttfs_cmd_t    cmd;
    ttfs_pkg::ttfs_status_t status;

    ttfs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ttfs_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .block_last    (block_last),
        .cmd           (cmd),
        .status        (status),
        .tick_start    (tick_start),
        .tick_index    (tick_index),
        .frame_in_tick (frame_in_tick),
        .tick_frames   (tick_frames),
        .chunk_start   (chunk_start)
    );

endmodule

`default_nettype wire

### src/ttfs_datapath.sv
// ----------------------------------------------------------------------------
// ttfs_datapath
// tick state, config registers, serial divider, offset multiplier, result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttfs_datapath
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ttfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ttfs_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              block_last,
    input  wire ttfs_pkg::ttfs_cmd_t               cmd,
    output ttfs_pkg::ttfs_status_t                 status,
    output logic                                   tick_start,
    output logic [14:0]                            tick_index,
    output logic [15:0]                            frame_in_tick,
    output logic [15:0]                            tick_frames,
    output logic                                   chunk_start
);

    localparam int CW = ttfs_pkg::TICK_COUNT_BITS;
    localparam int PW = ttfs_pkg::PROD_W;
    localparam int NW = ttfs_pkg::NUM_W;
    localparam int DW = ttfs_pkg::DEN_W;

    logic [ttfs_pkg::SR_W-1:0]  sample_rate_reg;
    logic [ttfs_pkg::BPM_W-1:0] bpm_reg;
    logic [ttfs_pkg::PPQ_W-1:0] ppq_reg;

    logic [15:0]   frames_done_reg;
    logic [CW-1:0] tick_count_reg;
    logic [30:0]   next_offset_reg;
    logic [15:0]   tick_length_reg;
    logic [31:0]   real_reg;
    logic          after_end_reg;
    logic          last_reg;

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [PW-1:0] prod_reg;

    logic          tick_start_reg;
    logic [14:0]   tick_index_reg;
    logic [15:0]   frame_in_tick_reg;
    logic [15:0]   tick_frames_reg;
    logic          chunk_start_reg;

    logic [23:0]   sr60;
    logic [DW:0]   rem_shift;
    logic [DW:0]   rem_diff;
    logic          rem_ge;
    logic [31:0]   real_next;
    logic [CW-1:0] count_next;
    logic [PW-1:0] prod_next;
    logic [31:0]   off_raw;
    logic [30:0]   next_off;
    logic [PW-1:0] wrap_wide;
    logic [31:0]   wrap_raw;
    logic [30:0]   wrap_off;
    logic [31:0]   len_diff;
    logic [15:0]   len_next;

    assign status.tick_due = (frames_done_reg >= tick_length_reg);

    // divider step
    assign sr60      = 24'(sample_rate_reg) * 24'd60;
    assign rem_shift = {rem_reg, quo_reg[NW-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    // quotient saturation and offset product
    assign real_next  = (|quo_reg[NW-1:32]) ? 32'hFFFF_FFFF : quo_reg[31:0];
    assign count_next = tick_count_reg + CW'(1);
    assign prod_next  = PW'(real_next) * PW'(count_next);

    // offsets and tick length
    assign off_raw   = 32'(prod_reg[PW-1:16]);
    assign next_off  = off_raw[31] ? 31'h7FFF_FFFF : off_raw[30:0];
    assign wrap_wide = {real_reg, {CW{1'b0}}};
    assign wrap_raw  = 32'(wrap_wide[PW-1:16]);
    assign wrap_off  = wrap_raw[31] ? 31'h7FFF_FFFF : wrap_raw[30:0];

    always_comb
    begin
        if (next_off < next_offset_reg)
        begin
            len_diff = {1'b0, wrap_off} - {1'b0, next_offset_reg};
        end
        else
        begin
            len_diff = {1'b0, next_off} - {1'b0, next_offset_reg};
        end
        if (|len_diff[31:16])
        begin
            len_next = 16'hFFFF;
        end
        else if (len_diff[15:0] == 16'd0)
        begin
            len_next = 16'd1;
        end
        else
        begin
            len_next = len_diff[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= ttfs_pkg::SR_W'(ttfs_pkg::RESET_SAMPLE_RATE);
            bpm_reg         <= ttfs_pkg::BPM_W'(ttfs_pkg::RESET_BPM_Q8);
            ppq_reg         <= ttfs_pkg::PPQ_W'(ttfs_pkg::RESET_PPQ);
            frames_done_reg <= '0;
            tick_count_reg  <= '0;
            next_offset_reg <= '0;
            tick_length_reg <= ttfs_pkg::RESET_HALF_LEN;
            real_reg        <= ttfs_pkg::RESET_REAL;
            after_end_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ttfs_pkg::CFG_SAMPLE_RATE:    sample_rate_reg <= cfg_data;
                    ttfs_pkg::CFG_TEMPO_BPM_Q8:   bpm_reg <= cfg_data[ttfs_pkg::BPM_W-1:0];
                    ttfs_pkg::CFG_TICKS_PER_BEAT: ppq_reg <= cfg_data[ttfs_pkg::PPQ_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.mul)
            begin
                real_reg       <= real_next;
                tick_count_reg <= count_next;
            end
            if (cmd.finish)
            begin
                next_offset_reg <= next_off;
                tick_length_reg <= len_next;
                frames_done_reg <= 16'd1;
                after_end_reg   <= last_reg;
            end
            else if (cmd.plain)
            begin
                frames_done_reg <= frames_done_reg + 16'd1;
                after_end_reg   <= block_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg  <= {sr60, 24'd0};
            rem_reg  <= '0;
            den_reg  <= DW'(ppq_reg) * DW'(bpm_reg);
            last_reg <= block_last;
        end
        else if (cmd.step)
        begin
            quo_reg <= {quo_reg[NW-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.finish)
        begin
            tick_start_reg    <= 1'b1;
            tick_index_reg    <= 15'(tick_count_reg);
            frame_in_tick_reg <= 16'd0;
            tick_frames_reg   <= len_next;
            chunk_start_reg   <= 1'b1;
        end
        else if (cmd.plain)
        begin
            tick_start_reg    <= 1'b0;
            tick_index_reg    <= 15'(tick_count_reg);
            frame_in_tick_reg <= frames_done_reg;
            tick_frames_reg   <= tick_length_reg;
            chunk_start_reg   <= after_end_reg;
        end
    end

    assign tick_start    = tick_start_reg;
    assign tick_index    = tick_index_reg;
    assign frame_in_tick = frame_in_tick_reg;
    assign tick_frames   = tick_frames_reg;
    assign chunk_start   = chunk_start_reg;

endmodule

`default_nettype wire

### src/ttfs_ctrl.sv
// ----------------------------------------------------------------------------
// ttfs_ctrl
// request sequencing: plain frames, divide / multiply / finish for tick starts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ttfs_ctrl
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    input  wire ttfs_pkg::ttfs_status_t  status,
    output ttfs_pkg::ttfs_cmd_t          cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [ttfs_pkg::DIV_CNT_W-1:0]  step_cnt_reg;
    logic [ttfs_pkg::DIV_CNT_W-1:0]  step_cnt_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_free;
    logic                            accept;
    logic                            last_step;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign last_step = (step_cnt_reg == ttfs_pkg::DIV_CNT_W'(ttfs_pkg::NUM_W - 1));
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.tick_due)
                    begin
                        cmd.start     = 1'b1;
                        step_cnt_next = '0;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        cmd.plain      = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.step      = 1'b1;
                step_cnt_next = step_cnt_reg + ttfs_pkg::DIV_CNT_W'(1);
                if (last_step)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TTFS_ASSERT_NEXT(a_tick_enters_div, accept && status.tick_due, state_reg == ST_DIV, "tick request did not start the divider")
    `TTFS_ASSERT_NEXT(a_plain_gives_result, accept && !status.tick_due, out_valid_reg, "plain request produced no result")
    `TTFS_ASSERT_NEXT(a_div_ends, state_reg == ST_DIV && last_step, state_reg == ST_MUL, "divider did not hand over to multiply")
    `TTFS_ASSERT_SAME(a_busy_no_accept, state_reg != ST_IDLE, !in_ready, "request taken while a tick is computed")
    `TTFS_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command")

endmodule

`default_nettype wire
